/* sv/erdm_pkg.sv */
// Package with types, status codes and constants for the extent runlist mapper.
`default_nettype none
package erdm_pkg;

  localparam int unsigned MaxRunsDefault = 32;

  typedef enum logic [1:0] {
    KIND_BEGIN  = 2'd0,
    KIND_BYTE   = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_RSVD   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_MAPPED    = 3'd0,
    ST_SPARSE    = 3'd1,
    ST_NOTFOUND  = 3'd2,
    ST_ACCEPTED  = 3'd3,
    ST_DONE      = 3'd4,
    ST_FULL      = 3'd5,
    ST_MALFORMED = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_COUNT  = 2'd2,
    PH_OFFSET = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_RD    = 3'd1,
    S_CMP   = 3'd2,
    S_HIT   = 3'd3,
    S_OFFS  = 3'd4,
    S_OUT   = 3'd5
  } fsm_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [62:0] vcn;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [62:0] lcn;
    logic [62:0] remaining_clusters;
  } rsp_t;

endpackage
`default_nettype wire

/* sv/extent_runlist_decode_and_map.sv */
// Extent runlist decoder and virtual-to-physical cluster mapper.
//
// Channel | Dir | Handshake         | Payload
// req     | in  | req_valid/ready_o | erdm_pkg::req_t
// rsp     | out | rsp_valid/ready_i | erdm_pkg::rsp_t
//
// Begin and list-byte requests go from S_RD to S_OUT; an offset field end adds S_OFFS.
// A lookup alternates S_RD and S_CMP per run visited, at most MAX_RUNS runs, then
// S_HIT on a hit, by one shared subtract and compare over the run memory read one entry at a time.
// Reset clears control state; table contents are valid only below the entry count.
// The response register holds while rsp_ready_i is low; no request is taken meanwhile.
`default_nettype none
module extent_runlist_decode_and_map #(
  parameter int unsigned MAX_RUNS = erdm_pkg::MaxRunsDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            req_valid_i,
  output logic                 req_ready_o,
  input  wire erdm_pkg::req_t  req_i,
  output logic                 rsp_valid_o,
  input  wire logic            rsp_ready_i,
  output erdm_pkg::rsp_t       rsp_o
);

  localparam int unsigned IW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int unsigned CW = $clog2(MAX_RUNS + 1);

  logic [63:0] vcn_mem [MAX_RUNS];
  logic [63:0] len_mem [MAX_RUNS];
  logic [63:0] lcn_mem [MAX_RUNS];
  logic        spr_mem [MAX_RUNS];

  erdm_pkg::fsm_e   state_q, state_d;
  erdm_pkg::phase_e phase_q, phase_d;
  erdm_pkg::req_t   req_q;
  logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic [3:0]  left_q, left_d, osz_q, osz_d, pos_q, pos_d;
  logic [63:0] acc_q, acc_d, rlcn_q, rlcn_d, nvcn_q, nvcn_d, pend_len_q, pend_len_d;
  logic [63:0] rd_vcn_q, rd_len_q, rd_lcn_q, d_q, d_d;
  logic        rd_spr_q;
  logic [63:0] sum_q, sum_d;
  erdm_pkg::rsp_t rsp_q, rsp_d;
  logic          we;
  logic [CW-1:0] w_idx;
  logic [63:0]   w_vcn, w_len, w_lcn;
  logic          w_spr;
  logic [63:0]   acc_n, delta;
  logic [63:0]   alu_a, alu_b, alu_y;

  assign alu_y = alu_a - alu_b;
  assign acc_n = acc_q | ({56'd0, req_q.data_byte} << {pos_q[2:0], 3'd0});

  always_ff @(posedge clk_i) begin
    if (we) begin
      vcn_mem[w_idx[IW-1:0]] <= w_vcn;
      len_mem[w_idx[IW-1:0]] <= w_len;
      lcn_mem[w_idx[IW-1:0]] <= w_lcn;
      spr_mem[w_idx[IW-1:0]] <= w_spr;
    end
    rd_vcn_q <= vcn_mem[idx_d[IW-1:0]];
    rd_len_q <= len_mem[idx_d[IW-1:0]];
    rd_lcn_q <= lcn_mem[idx_d[IW-1:0]];
    rd_spr_q <= spr_mem[idx_d[IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= erdm_pkg::S_IDLE;
      phase_q <= erdm_pkg::PH_IDLE;
      cnt_q <= '0; idx_q <= '0; left_q <= '0; osz_q <= '0; pos_q <= '0;
      acc_q <= '0; rlcn_q <= '0; nvcn_q <= '0;
    end else begin
      state_q <= state_d; phase_q <= phase_d;
      cnt_q <= cnt_d; idx_q <= idx_d; left_q <= left_d; osz_q <= osz_d; pos_q <= pos_d;
      acc_q <= acc_d; rlcn_q <= rlcn_d; nvcn_q <= nvcn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) req_q <= req_i;
    pend_len_q <= pend_len_d;
    d_q <= d_d;
    sum_q <= sum_d;
    rsp_q <= rsp_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      erdm_pkg::S_IDLE: if (req_valid_i) state_d = erdm_pkg::S_RD;
      erdm_pkg::S_RD: begin
        if (req_q.kind == erdm_pkg::KIND_LOOKUP && idx_q < cnt_q) state_d = erdm_pkg::S_CMP;
        else if (req_q.kind == erdm_pkg::KIND_BYTE && phase_q == erdm_pkg::PH_OFFSET &&
                 left_q == 4'd1) state_d = erdm_pkg::S_OFFS;
        else state_d = erdm_pkg::S_OUT;
      end
      erdm_pkg::S_CMP: state_d = (d_q < rd_len_q) ? erdm_pkg::S_HIT : erdm_pkg::S_RD;
      erdm_pkg::S_HIT, erdm_pkg::S_OFFS: state_d = erdm_pkg::S_OUT;
      erdm_pkg::S_OUT: if (rsp_ready_i) state_d = erdm_pkg::S_IDLE;
      default: state_d = erdm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    logic [3:0] cs, os;
    cs = req_q.data_byte[3:0];
    os = req_q.data_byte[7:4];
    phase_d = phase_q; cnt_d = cnt_q; idx_d = idx_q; left_d = left_q; osz_d = osz_q;
    pos_d = pos_q; acc_d = acc_q; rlcn_d = rlcn_q; nvcn_d = nvcn_q;
    pend_len_d = pend_len_q; d_d = d_q; sum_d = sum_q; rsp_d = rsp_q;
    we = 1'b0; w_idx = cnt_q; w_vcn = nvcn_q; w_len = acc_n; w_lcn = '0; w_spr = 1'b1;
    alu_a = '0; alu_b = '0;
    delta = acc_n;
    for (int k = 1; k < 8; k++) begin
      if (osz_q == 4'(k) && acc_n[8*k-1]) delta = acc_n | ~((64'd1 << (8*k)) - 64'd1);
    end
    case (state_q)
      erdm_pkg::S_IDLE: idx_d = '0;
      erdm_pkg::S_RD: begin
        rsp_d = '{status: erdm_pkg::ST_MALFORMED, lcn: '0, remaining_clusters: '0};
        case (req_q.kind)
          erdm_pkg::KIND_BEGIN: begin
            cnt_d = '0; nvcn_d = {1'b0, req_q.vcn}; rlcn_d = '0; left_d = '0; osz_d = '0;
            pos_d = '0; acc_d = '0; phase_d = erdm_pkg::PH_HEADER;
            rsp_d.status = erdm_pkg::ST_ACCEPTED;
          end
          erdm_pkg::KIND_LOOKUP: begin
            rsp_d.status = erdm_pkg::ST_NOTFOUND;
            alu_a = {1'b0, req_q.vcn}; alu_b = rd_vcn_q;
          end
          erdm_pkg::KIND_BYTE: begin
            case (phase_q)
              erdm_pkg::PH_HEADER: begin
                if (req_q.data_byte == 8'd0) begin
                  phase_d = erdm_pkg::PH_IDLE; rsp_d.status = erdm_pkg::ST_DONE;
                end else if (cs == 4'd0 || cs > 4'd8 || os > 4'd8) begin
                  phase_d = erdm_pkg::PH_IDLE;
                end else if (cnt_q >= CW'(MAX_RUNS)) begin
                  phase_d = erdm_pkg::PH_IDLE; rsp_d.status = erdm_pkg::ST_FULL;
                end else begin
                  left_d = cs; osz_d = os; pos_d = '0; acc_d = '0;
                  phase_d = erdm_pkg::PH_COUNT; rsp_d.status = erdm_pkg::ST_ACCEPTED;
                end
              end
              erdm_pkg::PH_COUNT: begin
                rsp_d.status = erdm_pkg::ST_ACCEPTED;
                acc_d = acc_n; pos_d = pos_q + 4'd1; left_d = left_q - 4'd1;
                if (left_q == 4'd1) begin
                  if (osz_q == 4'd0) begin
                    we = 1'b1; cnt_d = cnt_q + 1'b1; nvcn_d = nvcn_q + acc_n;
                    phase_d = erdm_pkg::PH_HEADER;
                  end else begin
                    pend_len_d = acc_n; left_d = osz_q; pos_d = '0; acc_d = '0;
                    phase_d = erdm_pkg::PH_OFFSET;
                  end
                end
              end
              erdm_pkg::PH_OFFSET: begin
                rsp_d.status = erdm_pkg::ST_ACCEPTED;
                acc_d = acc_n; pos_d = pos_q + 4'd1; left_d = left_q - 4'd1;
                alu_a = rlcn_q; alu_b = -delta;
                if (left_q == 4'd1) sum_d = alu_y;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
        if (req_q.kind == erdm_pkg::KIND_LOOKUP) d_d = alu_y;
      end
      erdm_pkg::S_CMP: begin
        alu_a = rd_len_q; alu_b = d_q;
        if (d_q < rd_len_q) begin
          rsp_d.remaining_clusters = alu_y[62:0];
          rsp_d.status = rd_spr_q ? erdm_pkg::ST_SPARSE : erdm_pkg::ST_MAPPED;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      erdm_pkg::S_HIT: begin
        alu_a = rd_lcn_q; alu_b = -d_q;
        if (!rd_spr_q) rsp_d.lcn = alu_y[62:0];
      end
      erdm_pkg::S_OFFS: begin
        if (sum_q[63]) begin
          phase_d = erdm_pkg::PH_IDLE; rsp_d.status = erdm_pkg::ST_MALFORMED;
        end else begin
          rlcn_d = sum_q; we = 1'b1; w_len = pend_len_q; w_lcn = sum_q; w_spr = 1'b0;
          cnt_d = cnt_q + 1'b1; nvcn_d = nvcn_q + pend_len_q;
          phase_d = erdm_pkg::PH_HEADER;
        end
      end
      default: ;
    endcase
  end

  assign req_ready_o = (state_q == erdm_pkg::S_IDLE);
  assign rsp_valid_o = (state_q == erdm_pkg::S_OUT);
  assign rsp_o       = rsp_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_RUNS)) else $error("entry count above table depth");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_ready_o && rsp_valid_o)) else $error("ready while response pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("response changed while stalled");
`endif

endmodule
`default_nettype wire

/* bench/extent_runlist_decode_and_map_tb.sv */
// Self-checking testbench for the extent runlist decoder and cluster mapper.
module extent_runlist_decode_and_map_tb;

  localparam int unsigned Runs = erdm_pkg::MaxRunsDefault;
  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned ItemGoal = 1550;
  localparam int unsigned QuietTail = 150;
  localparam int unsigned DrainCycles = 100;

  typedef struct {
    erdm_pkg::req_t    req;
    bit                typed;
    erdm_pkg::status_e st;
    logic [62:0]       lcn;
    logic [62:0]       rem;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  erdm_pkg::req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_ready_i = 1'b0;
  erdm_pkg::rsp_t rsp_o;

  extent_runlist_decode_and_map u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .req_valid_i(req_valid_i), .req_ready_o(req_ready_o), .req_i(req_i),
    .rsp_valid_o(rsp_valid_o), .rsp_ready_i(rsp_ready_i), .rsp_o(rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mirror of the extent table and list parser.
  logic [63:0] ext_vcn [Runs];
  logic [63:0] ext_len [Runs];
  logic [63:0] ext_lcn [Runs];
  bit          ext_sparse [Runs];
  int unsigned ext_count;
  erdm_pkg::phase_e list_phase;
  int unsigned field_left, off_bytes, field_pos;
  logic [63:0] field_acc, cur_lcn, cur_vcn;

  erdm_pkg::rsp_t mapping_q[$];
  int unsigned errors = 0;
  int unsigned useful_sent = 0;
  bit          quiet = 1'b0;
  bit          long_hold = 1'b0;

  function automatic void store_extent(logic [63:0] len, logic [63:0] lcn, bit sp);
    if (ext_count < Runs) begin
      ext_vcn[ext_count] = cur_vcn;
      ext_len[ext_count] = len;
      ext_lcn[ext_count] = lcn;
      ext_sparse[ext_count] = sp;
      cur_vcn = cur_vcn + len;
      ext_count++;
    end
  endfunction

  function automatic erdm_pkg::status_e parse_byte(logic [7:0] b);
    int unsigned cnt, off, nbits;
    logic [63:0] delta, sum;
    cnt = b[3:0];
    off = b[7:4];
    case (list_phase)
      erdm_pkg::PH_HEADER: begin
        if (b == 8'h00) begin
          list_phase = erdm_pkg::PH_IDLE;
          return erdm_pkg::ST_DONE;
        end
        if (cnt == 0 || cnt > 8 || off > 8) begin
          list_phase = erdm_pkg::PH_IDLE;
          return erdm_pkg::ST_MALFORMED;
        end
        if (ext_count >= Runs) begin
          list_phase = erdm_pkg::PH_IDLE;
          return erdm_pkg::ST_FULL;
        end
        field_left = cnt;
        off_bytes = off;
        field_pos = 0;
        field_acc = '0;
        list_phase = erdm_pkg::PH_COUNT;
        return erdm_pkg::ST_ACCEPTED;
      end
      erdm_pkg::PH_COUNT: begin
        field_acc |= 64'(b) << ((field_pos % 8) * 8);
        field_pos++;
        field_left--;
        if (field_left == 0) begin
          if (off_bytes == 0) begin
            store_extent(field_acc, '0, 1'b1);
            list_phase = erdm_pkg::PH_HEADER;
          end else begin
            ext_len[ext_count % Runs] = field_acc;
            field_left = off_bytes;
            field_pos = 0;
            field_acc = '0;
            list_phase = erdm_pkg::PH_OFFSET;
          end
        end
        return erdm_pkg::ST_ACCEPTED;
      end
      erdm_pkg::PH_OFFSET: begin
        field_acc |= 64'(b) << ((field_pos % 8) * 8);
        field_pos++;
        field_left--;
        if (field_left == 0) begin
          delta = field_acc;
          nbits = off_bytes * 8;
          if (nbits < 64 && delta[nbits-1]) delta |= ~((64'd1 << nbits) - 64'd1);
          sum = cur_lcn + delta;
          if (sum[63]) begin
            list_phase = erdm_pkg::PH_IDLE;
            return erdm_pkg::ST_MALFORMED;
          end
          cur_lcn = sum;
          store_extent(ext_len[ext_count % Runs], sum, 1'b0);
          list_phase = erdm_pkg::PH_HEADER;
        end
        return erdm_pkg::ST_ACCEPTED;
      end
      default: return erdm_pkg::ST_MALFORMED;
    endcase
  endfunction

  function automatic erdm_pkg::rsp_t map_predict(erdm_pkg::req_t r);
    erdm_pkg::rsp_t    o;
    erdm_pkg::status_e st;
    logic [63:0] v, d, lcn, rem;
    st = erdm_pkg::ST_MALFORMED;
    lcn = '0;
    rem = '0;
    v = {1'b0, r.vcn};
    case (erdm_pkg::kind_e'(r.kind))
      erdm_pkg::KIND_BEGIN: begin
        ext_count = 0;
        cur_vcn = v;
        cur_lcn = '0;
        field_left = 0;
        off_bytes = 0;
        field_pos = 0;
        field_acc = '0;
        list_phase = erdm_pkg::PH_HEADER;
        st = erdm_pkg::ST_ACCEPTED;
      end
      erdm_pkg::KIND_BYTE: st = parse_byte(r.data_byte);
      erdm_pkg::KIND_LOOKUP: begin
        st = erdm_pkg::ST_NOTFOUND;
        for (int unsigned i = 0; i < ext_count; i++) begin
          d = v - ext_vcn[i];
          if (d < ext_len[i]) begin
            rem = ext_len[i] - d;
            if (ext_sparse[i]) begin
              st = erdm_pkg::ST_SPARSE;
            end else begin
              st = erdm_pkg::ST_MAPPED;
              lcn = ext_lcn[i] + d;
            end
            break;
          end
        end
      end
      default: st = erdm_pkg::ST_MALFORMED;
    endcase
    o.status = st;
    o.lcn = lcn[62:0];
    o.remaining_clusters = rem[62:0];
    return o;
  endfunction

  task automatic issue(input erdm_pkg::req_t r, input bit typed = 1'b0,
                       input erdm_pkg::rsp_t want = '0);
    erdm_pkg::rsp_t e;
    bit   ignored;
    req_valid_i <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    ignored = (r.kind == erdm_pkg::KIND_RSVD) ||
              (r.kind == erdm_pkg::KIND_BYTE && list_phase == erdm_pkg::PH_IDLE);
    e = map_predict(r);
    mapping_q.insert(mapping_q.size(), typed ? want : e);
    if (!ignored) useful_sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  function automatic erdm_pkg::req_t mk(erdm_pkg::kind_e k, logic [7:0] b, logic [62:0] v);
    erdm_pkg::req_t r;
    r.kind = k;
    r.data_byte = b;
    r.vcn = v;
    return r;
  endfunction

  function automatic logic [62:0] rand63();
    return 63'({$urandom, $urandom});
  endfunction

  task automatic random_lookup();
    logic [63:0] v, span;
    int unsigned i;
    if (ext_count != 0 && $urandom_range(0, 3) != 0) begin
      i = $urandom_range(0, ext_count - 1);
      span = {$urandom, $urandom};
      v = ext_vcn[i];
      if (ext_len[i] != 0) v = v + span % ext_len[i];
      if ($urandom_range(0, 4) == 0) v = v + ext_len[i];
      issue(mk(erdm_pkg::KIND_LOOKUP, 8'($urandom), v[62:0]));
    end else begin
      issue(mk(erdm_pkg::KIND_LOOKUP, 8'($urandom), rand63()));
    end
  endtask

  task automatic random_list();
    logic [62:0] start;
    int unsigned runs, cnt, off;
    logic [7:0]  b;
    case ($urandom_range(0, 2))
      0: start = 63'($urandom_range(0, 1000));
      1: start = '1 - 63'($urandom_range(0, 1000));
      default: start = rand63();
    endcase
    issue(mk(erdm_pkg::KIND_BEGIN, 8'($urandom), start));
    runs = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 6);
    for (int unsigned n = 0; n < runs && list_phase != erdm_pkg::PH_IDLE; n++) begin
      cnt = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 2) : $urandom_range(1, 8);
      off = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 30) == 0) cnt = $urandom_range(0, 15);
      if ($urandom_range(0, 30) == 0) off = $urandom_range(9, 15);
      issue(mk(erdm_pkg::KIND_BYTE, {4'(off), 4'(cnt)}, rand63()));
      for (int unsigned j = 0; j < cnt + off && list_phase > erdm_pkg::PH_HEADER; j++) begin
        b = 8'($urandom);
        if (j == cnt + off - 1 && j >= cnt && $urandom_range(0, 3) != 0) b[7] = 1'b0;
        issue(mk(erdm_pkg::KIND_BYTE, b, rand63()));
        if ($urandom_range(0, 25) == 0) random_lookup();
      end
    end
    if (list_phase != erdm_pkg::PH_IDLE && $urandom_range(0, 5) != 0)
      issue(mk(erdm_pkg::KIND_BYTE, 8'h00, rand63()));
    repeat ($urandom_range(1, 6)) random_lookup();
  endtask

  task automatic random_noise();
    issue(mk(erdm_pkg::kind_e'($urandom_range(0, 3)), 8'($urandom), rand63()));
  endtask

  always @(posedge clk_i) begin
    erdm_pkg::rsp_t e;
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      if (mapping_q.size() == 0) begin
        $error("response with nothing expected: status %0d", rsp_o.status);
        errors++;
      end else begin
        e = mapping_q.pop_front();
        if (rsp_o.status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, rsp_o.status);
          errors++;
        end
        if (rsp_o.lcn !== e.lcn) begin
          $error("lcn: expected %0h, actual %0h", e.lcn, rsp_o.lcn);
          errors++;
        end
        if (rsp_o.remaining_clusters !== e.remaining_clusters) begin
          $error("remaining_clusters: expected %0h, actual %0h",
                 e.remaining_clusters, rsp_o.remaining_clusters);
          errors++;
        end
      end
    end
  end

  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        rsp_ready_i <= 1'b0;
        stall = 0;
        while (stall < 300) begin
          @(posedge clk_i);
          stall++;
        end
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        rsp_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        rsp_ready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    row_t plan[$];
    bit   held;
    bit   paused;
    held = 1'b0;
    paused = 1'b0;
    plan = '{
      '{mk(erdm_pkg::KIND_LOOKUP, 8'h00, 63'd0),   1, erdm_pkg::ST_NOTFOUND, '0, '0},
      '{mk(erdm_pkg::KIND_BYTE, 8'hFF, '1),        1, erdm_pkg::ST_MALFORMED, '0, '0},
      '{mk(erdm_pkg::KIND_RSVD, 8'hFF, '1),        1, erdm_pkg::ST_MALFORMED, '0, '0},
      '{mk(erdm_pkg::KIND_BEGIN, 8'h00, '1),       1, erdm_pkg::ST_ACCEPTED, '0, '0},
      '{mk(erdm_pkg::KIND_BYTE, 8'h11, '0),        1, erdm_pkg::ST_ACCEPTED, '0, '0},
      '{mk(erdm_pkg::KIND_BYTE, 8'h05, '0),        1, erdm_pkg::ST_ACCEPTED, '0, '0},
      '{mk(erdm_pkg::KIND_BYTE, 8'h80, '0),        1, erdm_pkg::ST_MALFORMED, '0, '0},
      '{mk(erdm_pkg::KIND_BEGIN, 8'h00, 63'd100),  1, erdm_pkg::ST_ACCEPTED, '0, '0},
      '{mk(erdm_pkg::KIND_BYTE, 8'h21, '0),        0, erdm_pkg::ST_ACCEPTED, '0, '0},
      '{mk(erdm_pkg::KIND_BYTE, 8'h10, '0),        0, erdm_pkg::ST_ACCEPTED, '0, '0},
      '{mk(erdm_pkg::KIND_BYTE, 8'h00, '0),        0, erdm_pkg::ST_ACCEPTED, '0, '0},
      '{mk(erdm_pkg::KIND_BYTE, 8'h01, '0),        0, erdm_pkg::ST_ACCEPTED, '0, '0},
      '{mk(erdm_pkg::KIND_BYTE, 8'h01, '0),        0, erdm_pkg::ST_ACCEPTED, '0, '0},
      '{mk(erdm_pkg::KIND_BYTE, 8'h04, '0),        0, erdm_pkg::ST_ACCEPTED, '0, '0},
      '{mk(erdm_pkg::KIND_LOOKUP, 8'h00, 63'd100), 0, erdm_pkg::ST_MAPPED, '0, '0},
      '{mk(erdm_pkg::KIND_LOOKUP, 8'h00, 63'd117), 0, erdm_pkg::ST_SPARSE, '0, '0},
      '{mk(erdm_pkg::KIND_LOOKUP, 8'h00, 63'd120), 1, erdm_pkg::ST_NOTFOUND, '0, '0},
      '{mk(erdm_pkg::KIND_LOOKUP, 8'h00, 63'd99),  1, erdm_pkg::ST_NOTFOUND, '0, '0},
      '{mk(erdm_pkg::KIND_BYTE, 8'h09, '0),        1, erdm_pkg::ST_MALFORMED, '0, '0},
      '{mk(erdm_pkg::KIND_BEGIN, 8'h00, '0),       1, erdm_pkg::ST_ACCEPTED, '0, '0},
      '{mk(erdm_pkg::KIND_BYTE, 8'h91, '0),        1, erdm_pkg::ST_MALFORMED, '0, '0},
      '{mk(erdm_pkg::KIND_BEGIN, 8'h00, '0),       1, erdm_pkg::ST_ACCEPTED, '0, '0},
      '{mk(erdm_pkg::KIND_BYTE, 8'h00, '0),        1, erdm_pkg::ST_DONE, '0, '0},
      '{mk(erdm_pkg::KIND_LOOKUP, 8'h00, '1),      1, erdm_pkg::ST_NOTFOUND, '0, '0}
    };
    ext_count = 0;
    list_phase = erdm_pkg::PH_IDLE;
    field_left = 0;
    off_bytes = 0;
    field_pos = 0;
    field_acc = '0;
    cur_lcn = '0;
    cur_vcn = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (plan[i])
      issue(plan[i].req, plan[i].typed, '{plan[i].st, plan[i].lcn, plan[i].rem});
    while (useful_sent < ItemGoal) begin
      if (!held && useful_sent > 500) begin
        held = 1'b1;
        long_hold = 1'b1;
      end
      if (!paused && useful_sent > 900) begin
        paused = 1'b1;
        req_valid_i <= 1'b0;
        @(posedge clk_i);
        while (mapping_q.size() != 0) @(posedge clk_i);
      end
      if (useful_sent > ItemGoal - QuietTail) quiet = 1'b1;
      if ($urandom_range(0, 9) == 0) random_noise();
      else random_list();
    end
    req_valid_i <= 1'b0;
    while (mapping_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/erdm_pkg.sv
sv/extent_runlist_decode_and_map.sv
bench/extent_runlist_decode_and_map_tb.sv
